// ===== rtl/core/vcgw_pkg.sv =====
// ----------------------------------------------------------------------------
// vcgw_pkg
// Shared types and constants for the velocity command gate with watchdog.
// ----------------------------------------------------------------------------
package vcgw_pkg;

    localparam int unsigned FWD_W     = 15;
    localparam int unsigned VEL_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 18;
    localparam int unsigned CFG_W     = 18;
    localparam int unsigned CFG_ADR_W = 2;
    localparam int unsigned IN_DATA_W = 128;
    localparam int unsigned OUT_DATA_W = 32;

    // register reset values
    localparam logic [FWD_W-1:0] MAX_FORWARD_RST = 15'd200;
    localparam logic [FWD_W-1:0] MAX_TURN_RST    = 15'd250;
    localparam logic [TMO_W-1:0] TIMEOUT_RST     = 18'd120000;

    // item kind carried in tuser
    typedef enum logic {
        FUNC_CMD = 1'b0,
        FUNC_PUB = 1'b1
    } func_t;

    // configuration register indexes
    typedef enum logic [CFG_ADR_W-1:0] {
        REG_MAX_FORWARD = 2'd0,
        REG_MAX_TURN    = 2'd1,
        REG_TIMEOUT     = 2'd2
    } reg_idx_t;

    // limited velocity command
    typedef struct packed {
        logic [FWD_W-1:0]        forward;
        logic signed [VEL_W-1:0] turn;
    } cmd_t;

    // raw command fields of one input transfer
    typedef struct packed {
        logic signed [VEL_W-1:0] ang_z;
        logic signed [VEL_W-1:0] ang_y;
        logic signed [VEL_W-1:0] ang_x;
        logic signed [VEL_W-1:0] lin_z;
        logic signed [VEL_W-1:0] lin_y;
        logic signed [VEL_W-1:0] lin_x;
        logic [TIME_W-1:0]       now_us;
    } item_t;

    // update request from the datapath to the watchdog state
    typedef struct packed {
        logic              upd;
        logic [TIME_W-1:0] now_us;
    } wd_ctrl_t;

endpackage

// ===== rtl/core/vcgw_limit.sv =====
// ----------------------------------------------------------------------------
// vcgw_limit
// Validity check and limiting of one velocity command.
// ----------------------------------------------------------------------------
module vcgw_limit import vcgw_pkg::*; (
    input  item_t            item,
    input  logic [FWD_W-1:0] max_forward,
    input  logic [FWD_W-1:0] max_turn,
    output cmd_t             cmd
);

    logic                    valid_cmd;
    logic [FWD_W-1:0]        fwd_raw;
    logic [FWD_W-1:0]        fwd_cap;
    logic signed [VEL_W-1:0] lim_pos;
    logic signed [VEL_W-1:0] lim_neg;
    logic signed [VEL_W-1:0] turn_clamp;

    // only forward motion and yaw are allowed
    assign valid_cmd = !item.lin_x[VEL_W-1] && (item.lin_y == '0) && (item.lin_z == '0)
                       && (item.ang_x == '0) && (item.ang_y == '0);

    // forward speed cap
    assign fwd_raw = item.lin_x[FWD_W-1:0];
    assign fwd_cap = (fwd_raw < max_forward) ? fwd_raw : max_forward;

    // symmetric turn clamp; limit fits 15 bits so the negation never overflows
    assign lim_pos = $signed({1'b0, max_turn});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (item.ang_z > lim_pos) begin
            turn_clamp = lim_pos;
        end else if (item.ang_z < lim_neg) begin
            turn_clamp = lim_neg;
        end else begin
            turn_clamp = item.ang_z;
        end
    end

    // rejected commands are held as all zero
    assign cmd.forward = valid_cmd ? fwd_cap : '0;
    assign cmd.turn    = valid_cmd ? turn_clamp : '0;

endmodule

// ===== rtl/core/vcgw_watchdog.sv =====
// ----------------------------------------------------------------------------
// vcgw_watchdog
// Held command, time stamp and freshness check for publish requests.
// ----------------------------------------------------------------------------
module vcgw_watchdog import vcgw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  wd_ctrl_t          ctrl,
    input  cmd_t              cmd_in,
    input  logic [TIME_W-1:0] pub_now_us,
    input  logic [TMO_W-1:0]  timeout_us,
    output cmd_t              pub_cmd
);

    cmd_t              held_reg;
    cmd_t              held_next;
    logic [TIME_W-1:0] stamp_reg;
    logic [TIME_W-1:0] stamp_next;
    logic              got_reg;
    logic              got_next;
    logic [TIME_W-1:0] age;
    logic              fresh;

    // every command, accepted or rejected, restamps the hold
    always_comb begin
        held_next  = held_reg;
        stamp_next = stamp_reg;
        got_next   = got_reg;
        if (ctrl.upd) begin
            held_next  = cmd_in;
            stamp_next = ctrl.now_us;
            got_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            stamp_reg <= '0;
            got_reg   <= 1'b0;
        end else begin
            held_reg  <= held_next;
            stamp_reg <= stamp_next;
            got_reg   <= got_next;
        end
    end

    // wrapping age; an earlier time reads as a very large age
    assign age   = pub_now_us - stamp_reg;
    assign fresh = got_reg && (age <= {{(TIME_W-TMO_W){1'b0}}, timeout_us});

    assign pub_cmd = fresh ? held_reg : '0;

endmodule

// ===== rtl/core/velocity_command_gate_watchdog_top.sv =====
// Publish path: a publish request passes the input register, then the result register,
//   where its result is offered; it waits in the input register while the result slot is full.
// Throughput: one item per cycle while no publish is stalled; the single-pass datapath
//   between the two registers sets this, and a command never waits on the result side.
// Reset: synchronous, active low; clears the held command, the stamp, both valid
//   flags, and returns the three configuration registers to their defaults.
// ----------------------------------------------------------------------------
// velocity_command_gate_watchdog_top
// Velocity command gate with timeout watchdog, stream in and stream out.
// ----------------------------------------------------------------------------
module velocity_command_gate_watchdog_top import vcgw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // now_us, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
    input  logic                  s_tuser,   // func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // out_forward, out_turn, one zero pad bit
);

    logic [FWD_W-1:0] max_forward_reg;
    logic [FWD_W-1:0] max_turn_reg;
    logic [TMO_W-1:0] timeout_reg;

    logic  in_valid_reg;
    func_t in_func_reg;
    item_t in_item_reg;

    logic  m_valid_reg;
    logic  m_valid_next;
    cmd_t  m_cmd_reg;

    logic     out_free;
    logic     in_consume;
    logic     is_cmd;
    cmd_t     lim_cmd;
    cmd_t     pub_cmd;
    wd_ctrl_t wd_ctrl;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_forward_reg <= MAX_FORWARD_RST;
            max_turn_reg    <= MAX_TURN_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_MAX_FORWARD: max_forward_reg <= cfg_wdata[FWD_W-1:0];
                REG_MAX_TURN:    max_turn_reg    <= cfg_wdata[FWD_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_wdata[TMO_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshake: a command always drains, a publish needs a free result slot
    assign out_free   = !m_valid_reg || m_tready;
    assign is_cmd     = (in_func_reg == FUNC_CMD);
    assign in_consume = in_valid_reg && (is_cmd || out_free);
    assign s_tready   = !in_valid_reg || in_consume;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= func_t'(s_tuser);
            in_item_reg <= item_t'(s_tdata);
        end
    end

    // command limiting
    vcgw_limit u_limit (
        .item        (in_item_reg),
        .max_forward (max_forward_reg),
        .max_turn    (max_turn_reg),
        .cmd         (lim_cmd)
    );

    // hold and freshness
    assign wd_ctrl.upd    = in_consume && is_cmd;
    assign wd_ctrl.now_us = in_item_reg.now_us;

    vcgw_watchdog u_watchdog (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (wd_ctrl),
        .cmd_in     (lim_cmd),
        .pub_now_us (in_item_reg.now_us),
        .timeout_us (timeout_reg),
        .pub_cmd    (pub_cmd)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (in_consume && !is_cmd) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_consume && !is_cmd) begin
            m_cmd_reg <= pub_cmd;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_cmd_reg.turn, m_cmd_reg.forward};

endmodule

// ===== rtl/core/vcgw_checker.sv =====
// ----------------------------------------------------------------------------
// vcgw_checker
// Port-level checks on the velocity command gate, bound to the top level.
// ----------------------------------------------------------------------------
module vcgw_checker import vcgw_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic seen_cmd_reg;

    // tracks whether any command transfer has gone in since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_cmd_reg <= 1'b0;
        end else if (s_tvalid && s_tready && (s_tuser == FUNC_CMD)) begin
            seen_cmd_reg <= 1'b1;
        end
    end

    // reset leaves the block empty and ready
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("block not idle after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // turn rate stays symmetric and the pad bit stays zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[31] && (m_tdata[30:15] != 16'h8000)))
        else $error("result out of range");

    // no command yet means a zero answer
    a_no_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !seen_cmd_reg) |-> (m_tdata == '0))
        else $error("nonzero result before any command");

endmodule

bind velocity_command_gate_watchdog_top vcgw_checker u_vcgw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
